[sv/rdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared types and constants of the radix digit decomposer.
// ----------------------------------------------------------------------------
package rdd_pkg;

  localparam int MAX_DIGITS_DEF  = 16;
  localparam int INDEX_WIDTH_DEF = 32;

  localparam int RADIX_W     = 9;
  localparam int COUNT_W     = 5;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 32;
  localparam int DIGIT_W     = 8;
  localparam int POS_W       = 4;
  localparam int OUT_DATA_W  = 16;

  localparam int RADIX_RESET = 2;
  localparam int COUNT_RESET = 8;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POWER,
    ST_CLAMP,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic pow_step;
    logic clamp;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic pow_done;
    logic div_last;
    logic last_digit;
    logic out_free;
  } dp_status_t;

endpackage

[sv/rdd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdd_cfg
// Configuration registers, stored already saturated to their usable range.
// ----------------------------------------------------------------------------
module rdd_cfg #(
  parameter int MAX_DIGITS = rdd_pkg::MAX_DIGITS_DEF,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rdd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rdd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [rdd_pkg::RADIX_W-1:0]         radix_o,
  output logic [CW-1:0]                       count_o
);

  localparam int CNT_RST = (rdd_pkg::COUNT_RESET > MAX_DIGITS) ? MAX_DIGITS
                                                                : rdd_pkg::COUNT_RESET;
  localparam int SW = CW + rdd_pkg::COUNT_W;

  logic [rdd_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [CW-1:0]               count_q, count_d;
  logic [rdd_pkg::RADIX_W-1:0] wr_radix;
  logic [SW-1:0]               wr_count;

  always_comb begin
    wr_radix = cfg_data_i[rdd_pkg::RADIX_W-1:0];
    if (wr_radix < rdd_pkg::RADIX_W'(rdd_pkg::RADIX_MIN)) begin
      wr_radix = rdd_pkg::RADIX_W'(rdd_pkg::RADIX_MIN);
    end else if (wr_radix > rdd_pkg::RADIX_W'(rdd_pkg::RADIX_MAX)) begin
      wr_radix = rdd_pkg::RADIX_W'(rdd_pkg::RADIX_MAX);
    end
    wr_count = SW'(cfg_data_i[rdd_pkg::COUNT_W-1:0]);
    if (wr_count == '0) begin
      wr_count = SW'(1);
    end else if (wr_count > SW'(MAX_DIGITS)) begin
      wr_count = SW'(MAX_DIGITS);
    end
  end

  always_comb begin
    radix_d = radix_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rdd_pkg::CFG_RADIX:       radix_d = wr_radix;
        rdd_pkg::CFG_DIGIT_COUNT: count_d = wr_count[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdd_pkg::RADIX_W'(rdd_pkg::RADIX_RESET);
      count_q <= CW'(CNT_RST);
    end else begin
      radix_q <= radix_d;
      count_q <= count_d;
    end
  end

  assign radix_o = radix_q;
  assign count_o = count_q;

endmodule

[sv/rdd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdd_ctrl
// Sequencer: power of the radix, clamp, then one long division per digit.
// ----------------------------------------------------------------------------
module rdd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rdd_pkg::dp_status_t status_i,
  output rdd_pkg::dp_cmd_t    cmd_o,
  output rdd_pkg::state_e     state_o
);

  rdd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rdd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rdd_pkg::ST_POWER;
      end
      rdd_pkg::ST_POWER: begin
        if (status_i.pow_done) state_d = rdd_pkg::ST_CLAMP;
      end
      rdd_pkg::ST_CLAMP: state_d = rdd_pkg::ST_DIVIDE;
      rdd_pkg::ST_DIVIDE: begin
        if (status_i.div_last) state_d = rdd_pkg::ST_EMIT;
      end
      rdd_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_digit ? rdd_pkg::ST_IDLE : rdd_pkg::ST_DIVIDE;
        end
      end
      default: state_d = rdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rdd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rdd_pkg::ST_POWER:  cmd_o.pow_step = !status_i.pow_done;
      rdd_pkg::ST_CLAMP:  cmd_o.clamp    = 1'b1;
      rdd_pkg::ST_DIVIDE: cmd_o.div_step = 1'b1;
      rdd_pkg::ST_EMIT:   cmd_o.emit     = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[sv/rdd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdd_dp
// Datapath: radix power with overflow flag, clamp, byte-wise long division
// and the output register.
// ----------------------------------------------------------------------------
module rdd_dp #(
  parameter int MAX_DIGITS  = rdd_pkg::MAX_DIGITS_DEF,
  parameter int INDEX_WIDTH = rdd_pkg::INDEX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rdd_pkg::dp_cmd_t                   cmd_i,
  output rdd_pkg::dp_status_t                status_o,
  input  logic [rdd_pkg::RADIX_W-1:0]        radix_i,
  input  logic [CW-1:0]                      count_i,
  input  logic [rdd_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [rdd_pkg::DIGIT_W-1:0]        digit_o,
  output logic [rdd_pkg::POS_W-1:0]          pos_o,
  output logic                               clamped_o,
  output logic                               last_o
);

  localparam int W    = INDEX_WIDTH;
  localparam int NCH  = (W + 7) / 8;
  localparam int DW   = NCH * 8;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PW   = W + rdd_pkg::RADIX_W;

  logic [W-1:0]   p_q, p_d;
  logic           ovf_q, ovf_d;
  logic [DW-1:0]  ks_q, ks_d;
  logic [7:0]     rem_q, rem_d;
  logic [CHW-1:0] chunk_q, chunk_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           clamp_q, clamp_d;

  logic           ovalid_q, ovalid_d;
  logic [7:0]     digit_q, digit_d;
  logic [rdd_pkg::POS_W-1:0] pos_q, pos_d;
  logic           oclamp_q, oclamp_d;
  logic           olast_q, olast_d;

  logic [W-1:0]   in_ext;
  logic [PW-1:0]  prod;
  logic [7:0]     step_rem;
  logic [8:0]     trial;
  logic [7:0]     qbits;
  logic [7:0]     top_byte;
  logic           last_digit;
  logic           out_free;

  assign in_ext = W'(in_data_i);
  assign prod   = PW'(p_q) * PW'(radix_i);
  assign top_byte = ks_q[DW-1 -: 8];

  // eight restoring steps on a byte of the dividend
  always_comb begin
    step_rem = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int b = 7; b >= 0; b--) begin
      trial = {step_rem, top_byte[b]};
      if (trial >= radix_i) begin
        step_rem = 8'(trial - radix_i);
        qbits[b] = 1'b1;
      end else begin
        step_rem = trial[7:0];
      end
    end
  end

  assign last_digit = (cnt_q == count_i - CW'(1));
  assign out_free   = !ovalid_q || out_ready_i;

  always_comb begin
    p_d      = p_q;
    ovf_d    = ovf_q;
    ks_d     = ks_q;
    rem_d    = rem_q;
    chunk_d  = chunk_q;
    cnt_d    = cnt_q;
    clamp_d  = clamp_q;
    ovalid_d = ovalid_q && !out_ready_i;
    digit_d  = digit_q;
    pos_d    = pos_q;
    oclamp_d = oclamp_q;
    olast_d  = olast_q;

    if (cmd_i.load) begin
      ks_d  = DW'(in_ext);
      p_d   = W'(1);
      ovf_d = 1'b0;
      cnt_d = '0;
    end
    if (cmd_i.pow_step) begin
      // power beyond the index range: no clamp for this item
      if (prod[PW-1:W] != '0) begin
        ovf_d = 1'b1;
      end else begin
        p_d = prod[W-1:0];
      end
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.clamp) begin
      if (!ovf_q && (ks_q[W-1:0] >= p_q)) begin
        ks_d    = DW'(p_q - W'(1));
        clamp_d = 1'b1;
      end else begin
        clamp_d = 1'b0;
      end
      cnt_d   = '0;
      rem_d   = '0;
      chunk_d = '0;
    end
    if (cmd_i.div_step) begin
      ks_d    = (ks_q << 8) | DW'(qbits);
      rem_d   = step_rem;
      chunk_d = chunk_q + CHW'(1);
    end
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
      digit_d  = rem_q;
      pos_d    = rdd_pkg::POS_W'(cnt_q);
      oclamp_d = clamp_q;
      olast_d  = last_digit;
      rem_d    = '0;
      chunk_d  = '0;
      cnt_d    = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      ovf_q    <= 1'b0;
      cnt_q    <= '0;
      chunk_q  <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      ovf_q    <= ovf_d;
      cnt_q    <= cnt_d;
      chunk_q  <= chunk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    ks_q     <= ks_d;
    rem_q    <= rem_d;
    clamp_q  <= clamp_d;
    digit_q  <= digit_d;
    pos_q    <= pos_d;
    oclamp_q <= oclamp_d;
    olast_q  <= olast_d;
  end

  assign status_o.pow_done   = ovf_q || (cnt_q == count_i);
  assign status_o.div_last   = (chunk_q == CHW'(NCH - 1));
  assign status_o.last_digit = last_digit;
  assign status_o.out_free   = out_free;

  assign out_valid_o = ovalid_q;
  assign digit_o     = digit_q;
  assign pos_o       = pos_q;
  assign clamped_o   = oclamp_q;
  assign last_o      = olast_q;

endmodule

[sv/radix_digit_decomposer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_decomposer
// Splits an index into digit_count base-radix digits, least significant
// first, after clamping it to radix^digit_count - 1.
// ----------------------------------------------------------------------------
// sequence: accept, power steps up to radix^n (n the digit count) or overflow,
//   clamp, then per digit a byte-wise divide over ceil(INDEX_WIDTH / 8) bytes and an emit
// rate: set by the byte-wise long division and the one multiplier of the power
//   loop; a new index is taken only once the last digit of the previous one is emitted
// reset: radix 2, digit count 8, sequencer idle, output empty
module radix_digit_decomposer #(
  parameter int MAX_DIGITS  = rdd_pkg::MAX_DIGITS_DEF,
  parameter int INDEX_WIDTH = rdd_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rdd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rdd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rdd_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // combo_index
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rdd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // digit_value, digit_position
  output logic                              m_axis_tuser,   // clamped
  output logic                              m_axis_tlast    // last_digit
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [rdd_pkg::RADIX_W-1:0] radix;
  logic [CW-1:0]               count;
  rdd_pkg::dp_cmd_t            cmd;
  rdd_pkg::dp_status_t         status;
  rdd_pkg::state_e             state;
  logic [rdd_pkg::DIGIT_W-1:0] digit;
  logic [rdd_pkg::POS_W-1:0]   pos;

  rdd_cfg #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .radix_o    (radix),
    .count_o    (count)
  );

  rdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  rdd_dp #(
    .MAX_DIGITS  (MAX_DIGITS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .radix_i     (radix),
    .count_i     (count),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .digit_o     (digit),
    .pos_o       (pos),
    .clamped_o   (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(rdd_pkg::OUT_DATA_W - rdd_pkg::DIGIT_W - rdd_pkg::POS_W){1'b0}},
                         pos, digit};

  // busy right after an index is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && (state == rdd_pkg::ST_POWER))
    else $error("sequencer did not leave idle after accept");

  // a digit always lies below the radix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, digit} < radix))
    else $error("digit not below radix");

  // a new beat is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output beat overwritten");

endmodule
